// File: design/pst_pkg.sv
// pst_pkg: widths, status types and constants for the prime-square tester.
// No dependencies; imported by prime_square_test, pst_isqrt, pst_divider and pst_num_if.

package pst_pkg;

  localparam int NUM_WIDTH = 64;
  // Root is half the (even-padded) number width.
  localparam int ROOT_W = (NUM_WIDTH + 1) / 2;
  localparam int SQ_W = 2 * ROOT_W;
  // Partial remainder of the square root: two bits above the root.
  localparam int REM_W = ROOT_W + 2;
  // Trial divisors reach floor(sqrt(root)) + 1; at least 4 bits so 11 fits.
  localparam int DIV_W = ((ROOT_W + 1) / 2 + 1 > 4) ? (ROOT_W + 1) / 2 + 1 : 4;
  localparam int DSQ_W = 2 * DIV_W;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  localparam logic [DIV_W-1:0] FIRST_TRIAL = DIV_W'(11);
  localparam logic [DSQ_W-1:0] FIRST_TRIAL_SQ = DSQ_W'(121);
  localparam logic [1:0] SP_FIRST = 2'd0;
  localparam logic [1:0] SP_LAST = 2'd3;

  // Status of a serial unit: done pulses once, zero is the final remainder test.
  typedef struct packed {
    logic done;
    logic zero;
  } pst_unit_stat_t;

  function automatic logic [DIV_W-1:0] small_prime(input logic [1:0] idx);
    logic [DIV_W-1:0] p;
    unique case (idx)
      2'd0: p = DIV_W'(2);
      2'd1: p = DIV_W'(3);
      2'd2: p = DIV_W'(5);
      default: p = DIV_W'(7);
    endcase
    return p;
  endfunction

endpackage

// File: design/pst_if.sv
// pst_num_if / pst_res_if: valid-ready channels for the number and the verdict.
// Depends on pst_pkg for NUM_WIDTH.

interface pst_num_if
  import pst_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [NUM_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface pst_res_if;
  logic valid;
  logic ready;
  logic is_prime_square;

  modport source (output valid, output is_prime_square, input ready);
  modport sink (input valid, input is_prime_square, output ready);
endinterface

// File: design/prime_square_test.sv
// prime_square_test: tells whether a number is the square of a prime. One transaction in
// gives one verdict out. The bit-serial root unit runs first, then the root is divided
// by 2, 3, 5 and 7 on the shared bit-serial divider, and every candidate d = 11, 12, ...
// with d*d <= root gets a bound check, then a division on the same divider, one
// quotient bit per cycle. One number is worked on at a time; the next is taken as soon
// as the verdict sits in the output register.
// Depends on pst_pkg, pst_if, pst_isqrt and pst_divider.

module prime_square_test
  import pst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pst_num_if.sink   req,
  pst_res_if.source res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SQRT  = 6'b000010,
    S_SMALL = 6'b000100,
    S_NEXT  = 6'b001000,
    S_TRIAL = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [1:0]       idx, idx_next;
  logic [DIV_W-1:0] d, d_next;
  logic [DSQ_W-1:0] dsq, dsq_next;
  logic             verdict, verdict_next;
  logic             res_valid;
  logic             res_bit;
  logic             res_load;
  logic             accept;
  logic             div_go;
  logic [DIV_W-1:0] div_dvs;
  logic [ROOT_W-1:0] root;
  pst_unit_stat_t   sq_stat;
  pst_unit_stat_t   dv_stat;

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign res.valid = res_valid;
  assign res.is_prime_square = res_bit;

  pst_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .number (req.number),
    .root   (root),
    .stat   (sq_stat)
  );

  pst_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (root),
    .divisor  (div_dvs),
    .stat     (dv_stat)
  );

  always_comb begin
    state_next = state;
    idx_next = idx;
    d_next = d;
    dsq_next = dsq;
    verdict_next = verdict;
    div_go = 1'b0;
    div_dvs = d;
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_SQRT;
      end
      S_SQRT: begin
        if (sq_stat.done) begin
          if (!sq_stat.zero || root == ROOT_W'(1)) begin
            verdict_next = 1'b0;
            state_next = S_DONE;
          end else begin
            idx_next = SP_FIRST;
            div_go = 1'b1;
            div_dvs = small_prime(SP_FIRST);
            state_next = S_SMALL;
          end
        end
      end
      S_SMALL: begin
        if (dv_stat.done) begin
          // a multiple of the prime is fine only when it is the prime itself
          if (dv_stat.zero && root != ROOT_W'(small_prime(idx))) begin
            verdict_next = 1'b0;
            state_next = S_DONE;
          end else if (idx == SP_LAST) begin
            d_next = FIRST_TRIAL;
            dsq_next = FIRST_TRIAL_SQ;
            state_next = S_NEXT;
          end else begin
            idx_next = idx + 2'd1;
            div_go = 1'b1;
            div_dvs = small_prime(idx + 2'd1);
          end
        end
      end
      S_NEXT: begin
        if (dsq > DSQ_W'(root)) begin
          verdict_next = 1'b1;
          state_next = S_DONE;
        end else begin
          div_go = 1'b1;
          div_dvs = d;
          state_next = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (dv_stat.done) begin
          if (dv_stat.zero) begin
            verdict_next = 1'b0;
            state_next = S_DONE;
          end else begin
            d_next = d + DIV_W'(1);
            // (d+1)^2 = d^2 + 2d + 1
            dsq_next = dsq + DSQ_W'({d, 1'b1});
            state_next = S_NEXT;
          end
        end
      end
      S_DONE: begin
        if (!res_valid || res.ready) begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    d <= d_next;
    dsq <= dsq_next;
    verdict <= verdict_next;
    if (res_load) res_bit <= verdict;
  end

endmodule

// File: design/pst_isqrt.sv
// pst_isqrt: digit-serial integer square root, one root bit per cycle.
// Depends on pst_pkg. zero in the status flags an exact square.

module pst_isqrt
  import pst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] number,
  output logic [ROOT_W-1:0]    root,
  output pst_unit_stat_t       stat
);

  logic             running;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  nsh;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_t;
  logic [REM_W-1:0] trial;
  logic             ge;

  // Partial remainder stays below 2^ROOT_W before the shift, so its top bits drop.
  assign rem_t = {rem[REM_W-3:0], nsh[SQ_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign ge = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= CNT_W'(ROOT_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= SQ_W'(number);
      rem <= '0;
      root <= '0;
    end else if (running) begin
      nsh <= {nsh[SQ_W-3:0], 2'b00};
      rem <= ge ? rem_t - trial : rem_t;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule

// File: design/pst_divider.sv
// pst_divider: restoring bit-serial remainder, one dividend bit per cycle.
// Depends on pst_pkg. zero in the status flags an exact division.

module pst_divider
  import pst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ROOT_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output pst_unit_stat_t    stat
);

  logic             running;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [ROOT_W-1:0] qsh;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   rem_t;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign rem_t = {rem, qsh[ROOT_W-1]};
  assign diff = rem_t - {1'b0, dvs};
  assign ge = rem_t >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= CNT_W'(ROOT_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      qsh <= {qsh[ROOT_W-2:0], 1'b0};
      rem <= ge ? diff[DIV_W-1:0] : rem_t[DIV_W-1:0];
    end
  end

  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule

// File: design/pst_checker.sv
// pst_checker: port-level checks on prime_square_test, bound to the top level.
// Depends only on the top level's ports.

module pst_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_data
);

  // a number is worked on before the next one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon after a transaction");

  // a fresh verdict frees the input side in the same cycle
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("verdict issued while input side still busy");

  // an idle block with nothing offered stays idle
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> in_ready)
    else $error("block left idle without a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled verdict dropped or changed");

endmodule

bind prime_square_test pst_checker u_pst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_data  (res.is_prime_square)
);
